### rtl/srarq_pkg.sv
// Shared types and constants for the selective-repeat ARQ window engine.
// No dependencies; used by every module under rtl/.
package srarq_pkg;

    localparam int WINDOW_SLOTS  = 16;
    localparam int PENDING_DEPTH = 64;
    localparam int FIFO_DEPTH    = 2;
    localparam logic [15:0] MIN_FRAME = 16'd5;
    localparam logic [31:0] RESEND_RESET = 32'd100000;

    localparam logic [1:0] CMD_QUEUE  = 2'd0;
    localparam logic [1:0] CMD_FRAME  = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;

    localparam logic [1:0] KIND_XMIT    = 2'd0;
    localparam logic [1:0] KIND_RESEND  = 2'd1;
    localparam logic [1:0] KIND_DELIVER = 2'd2;
    localparam logic [1:0] KIND_REJECT  = 2'd3;

    typedef enum logic [1:0] {
        OP_QUEUE,
        OP_FRAME,
        OP_UPDATE,
        OP_DROP
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_XMIT,
        ST_RESEND
    } t_state;

    typedef struct packed {
        t_op         op;
        logic [7:0]  mseq;
        logic [7:0]  pnext;
        logic [15:0] pbits;
        logic [31:0] now;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

endpackage

### rtl/selective_repeat_arq_window.sv
// Selective-repeat ARQ window engine, top level.
// Queue and frame transactions: one per cycle unless the output stalls, via the result register.
// Update: the sequencer starts, then gives one result per cycle unless the output stalls,
// transmits or else resends (up to 16), after a resend decision step for resends.
// Synchronous active-low reset clears all window state; resend interval resets to 100000.
module selective_repeat_arq_window #(
    parameter int PENDING_DEPTH = srarq_pkg::PENDING_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_frame_length,
    input  logic [7:0]  i_message_seq,
    input  logic [7:0]  i_peer_next,
    input  logic [15:0] i_peer_bitmap_in,
    input  logic [31:0] i_now,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_seq,
    output logic [7:0]  o_ack_next,
    output logic [15:0] o_ack_bitmap,
    output logic        o_last
);

    logic             fifo_full, push, pop;
    srarq_pkg::t_item item;
    srarq_pkg::t_head head;

    srarq_front u_front (
        .i_valid(i_in_valid), .i_fifo_full(fifo_full), .i_cmd(i_cmd),
        .i_frame_length(i_frame_length), .i_message_seq(i_message_seq),
        .i_peer_next(i_peer_next), .i_peer_bitmap_in(i_peer_bitmap_in),
        .i_now(i_now), .o_ready(o_in_ready), .o_push(push), .o_item(item)
    );

    srarq_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_item(item),
        .i_pop(pop), .o_full(fifo_full), .o_head(head)
    );

    srarq_back #(.PENDING_DEPTH(PENDING_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data), .i_head(head), .o_pop(pop),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_kind(o_kind),
        .o_seq(o_seq), .o_ack_next(o_ack_next), .o_ack_bitmap(o_ack_bitmap),
        .o_last(o_last)
    );

endmodule

### rtl/srarq_front.sv
// Front end: decodes each input transaction into an operation for the queue.
// Depends on srarq_pkg.
module srarq_front (
    input  logic                 i_valid,
    input  logic                 i_fifo_full,
    input  logic [1:0]           i_cmd,
    input  logic [15:0]          i_frame_length,
    input  logic [7:0]           i_message_seq,
    input  logic [7:0]           i_peer_next,
    input  logic [15:0]          i_peer_bitmap_in,
    input  logic [31:0]          i_now,
    output logic                 o_ready,
    output logic                 o_push,
    output srarq_pkg::t_item     o_item
);

    srarq_pkg::t_op op;

    always_comb begin
        case (i_cmd)
            srarq_pkg::CMD_QUEUE:  op = srarq_pkg::OP_QUEUE;
            srarq_pkg::CMD_FRAME:  op = (i_frame_length >= srarq_pkg::MIN_FRAME) ?
                                        srarq_pkg::OP_FRAME : srarq_pkg::OP_DROP;
            srarq_pkg::CMD_UPDATE: op = srarq_pkg::OP_UPDATE;
            default:               op = srarq_pkg::OP_DROP;
        endcase
    end

    // drop short frames and unknown commands here; they never reach the queue
    assign o_ready = !i_fifo_full;
    assign o_push  = i_valid && !i_fifo_full && (op != srarq_pkg::OP_DROP);

    assign o_item.op    = op;
    assign o_item.mseq  = i_message_seq;
    assign o_item.pnext = i_peer_next;
    assign o_item.pbits = i_peer_bitmap_in;
    assign o_item.now   = i_now;

endmodule

### rtl/srarq_fifo.sv
// Short show-ahead queue between the front end and the window engine.
// Depends on srarq_pkg.
module srarq_fifo #(
    parameter int DEPTH = srarq_pkg::FIFO_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  srarq_pkg::t_item  i_item,
    input  logic              i_pop,
    output logic              o_full,
    output srarq_pkg::t_head  o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    srarq_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_comb begin
        n_wr  = i_push ? bump(r_wr) : r_wr;
        n_rd  = i_pop  ? bump(r_rd) : r_rd;
        n_cnt = r_cnt + CW'(i_push) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_full       = (r_cnt == CW'(DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_mem[r_rd];

endmodule

### rtl/srarq_back.sv
// Window engine: sequence and ack state, transmit/retransmit sequencer, output register.
// Depends on srarq_pkg.
module srarq_back #(
    parameter int PENDING_DEPTH = srarq_pkg::PENDING_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [31:0]       i_cfg_wr_data,
    input  srarq_pkg::t_head  i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_kind,
    output logic [7:0]        o_seq,
    output logic [7:0]        o_ack_next,
    output logic [15:0]       o_ack_bitmap,
    output logic              o_last
);

    localparam int PW = $clog2(PENDING_DEPTH + 1);
    localparam logic [7:0] WIN = 8'(srarq_pkg::WINDOW_SLOTS);

    srarq_pkg::t_state r_state, n_state;
    logic [7:0]  r_nss, n_nss, r_rne, n_rne, r_pne, n_pne;
    logic [15:0] r_rbm, n_rbm, r_pbm, n_pbm, r_rmask, n_rmask;
    logic [31:0] r_lrt, n_lrt, r_now, n_now, r_interval;
    logic [PW-1:0] r_pending, n_pending;
    logic        r_out_valid, n_out_valid, r_last, n_last;
    logic [1:0]  r_kind, n_kind;
    logic [7:0]  r_seq, n_seq, r_ack_next, n_ack_next;
    logic [15:0] r_ack_bitmap, n_ack_bitmap;

    logic        out_free, can_tx, resend_due;
    logic [7:0]  outstanding, clip, fr_idx, dist_new, dist_old;
    logic [15:0] fr_bm, clip_mask, rm_rest;
    logic [16:0] fr_ext;
    logic [4:0]  fr_ones;
    logic [3:0]  rm_low;
    logic        fr_new;

    assign out_free    = !r_out_valid || i_out_ready;
    assign outstanding = r_nss - r_pne;
    assign can_tx      = (r_pending != '0) && (outstanding < WIN);
    assign resend_due  = ((r_now - r_lrt) > r_interval) && (outstanding != '0);
    assign clip        = (outstanding > WIN) ? WIN : outstanding;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            clip_mask[i] = (8'(i) < clip);
        end
    end

    // received frame: mark, then slide past the run of received messages
    always_comb begin
        fr_idx   = i_head.item.mseq - r_rne;
        fr_new   = (fr_idx < WIN) && !r_rbm[fr_idx[3:0]];
        fr_bm    = r_rbm | (16'd1 << fr_idx[3:0]);
        fr_ext   = {1'b0, fr_bm};
        fr_ones  = 5'd16;
        for (int i = 16; i >= 0; i--) begin
            if (!fr_ext[i]) fr_ones = 5'(i);
        end
        dist_new = r_nss - i_head.item.pnext;
        dist_old = r_nss - r_pne;
    end

    always_comb begin
        rm_low = '0;
        for (int i = 15; i >= 0; i--) begin
            if (r_rmask[i]) rm_low = 4'(i);
        end
        rm_rest = r_rmask & ~(16'd1 << rm_low);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            srarq_pkg::ST_IDLE: begin
                if (i_head.valid && out_free &&
                    i_head.item.op == srarq_pkg::OP_UPDATE) begin
                    n_state = srarq_pkg::ST_XMIT;
                end
            end
            srarq_pkg::ST_XMIT: begin
                if (can_tx) begin
                    if (out_free && (r_pending == PW'(1) || outstanding == WIN - 8'd1)) begin
                        n_state = srarq_pkg::ST_IDLE;
                    end
                end else if (resend_due && ((~r_pbm & clip_mask) != '0)) begin
                    n_state = srarq_pkg::ST_RESEND;
                end else begin
                    n_state = srarq_pkg::ST_IDLE;
                end
            end
            srarq_pkg::ST_RESEND: begin
                if (out_free && rm_rest == '0) n_state = srarq_pkg::ST_IDLE;
            end
            default: n_state = srarq_pkg::ST_IDLE;
        endcase
    end

    // datapath and results
    always_comb begin
        n_nss = r_nss; n_rne = r_rne; n_rbm = r_rbm; n_pne = r_pne; n_pbm = r_pbm;
        n_lrt = r_lrt; n_now = r_now; n_pending = r_pending; n_rmask = r_rmask;
        n_out_valid = r_out_valid && !i_out_ready;
        n_kind = r_kind; n_seq = r_seq; n_ack_next = r_ack_next;
        n_ack_bitmap = r_ack_bitmap; n_last = r_last;
        o_pop = 1'b0;
        case (r_state)
            srarq_pkg::ST_IDLE: begin
                if (i_head.valid && out_free) begin
                    o_pop = 1'b1;
                    n_now = i_head.item.now;
                    case (i_head.item.op)
                        srarq_pkg::OP_QUEUE: begin
                            if (r_pending == PW'(PENDING_DEPTH)) begin
                                n_out_valid = 1'b1; n_kind = srarq_pkg::KIND_REJECT;
                                n_seq = '0; n_ack_next = '0; n_ack_bitmap = '0;
                                n_last = 1'b1;
                            end else begin
                                n_pending = r_pending + PW'(1);
                            end
                        end
                        srarq_pkg::OP_FRAME: begin
                            if (dist_new <= dist_old) begin
                                n_pne = i_head.item.pnext;
                                n_pbm = i_head.item.pbits;
                            end
                            if (fr_new) begin
                                n_rne = r_rne + 8'(fr_ones);
                                n_rbm = 16'(fr_ext >> fr_ones);
                                n_out_valid = 1'b1; n_kind = srarq_pkg::KIND_DELIVER;
                                n_seq = i_head.item.mseq;
                                n_ack_next = r_rne + 8'(fr_ones);
                                n_ack_bitmap = 16'(fr_ext >> fr_ones);
                                n_last = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            srarq_pkg::ST_XMIT: begin
                if (can_tx) begin
                    if (out_free) begin
                        n_out_valid = 1'b1; n_kind = srarq_pkg::KIND_XMIT;
                        n_seq = r_nss; n_ack_next = r_rne; n_ack_bitmap = r_rbm;
                        n_last = (r_pending == PW'(1)) || (outstanding == WIN - 8'd1);
                        n_lrt = r_now;
                        n_nss = r_nss + 8'd1;
                        n_pending = r_pending - PW'(1);
                    end
                end else if (resend_due) begin
                    n_lrt = r_now;
                    n_rmask = ~r_pbm & clip_mask;
                end
            end
            srarq_pkg::ST_RESEND: begin
                if (out_free) begin
                    n_out_valid = 1'b1; n_kind = srarq_pkg::KIND_RESEND;
                    n_seq = r_pne + 8'(rm_low); n_ack_next = r_rne; n_ack_bitmap = r_rbm;
                    n_last = (rm_rest == '0);
                    n_rmask = rm_rest;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srarq_pkg::ST_IDLE;
            r_nss <= '0; r_rne <= '0; r_rbm <= '0; r_pne <= '0; r_pbm <= '0;
            r_lrt <= '0; r_pending <= '0; r_out_valid <= 1'b0;
            r_interval <= srarq_pkg::RESEND_RESET;
        end else begin
            r_state <= n_state;
            r_nss <= n_nss; r_rne <= n_rne; r_rbm <= n_rbm; r_pne <= n_pne; r_pbm <= n_pbm;
            r_lrt <= n_lrt; r_pending <= n_pending; r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) r_interval <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now <= n_now; r_rmask <= n_rmask;
        r_kind <= n_kind; r_seq <= n_seq; r_ack_next <= n_ack_next;
        r_ack_bitmap <= n_ack_bitmap; r_last <= n_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_seq        = r_seq;
    assign o_ack_next   = r_ack_next;
    assign o_ack_bitmap = r_ack_bitmap;
    assign o_last       = r_last;

endmodule

### tb/sv/selective_repeat_arq_window_tb.sv
// Self-checking testbench for selective_repeat_arq_window: queue, frame and update
// transactions checked against an in-bench window model. Depends on srarq_pkg.
module selective_repeat_arq_window_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 24;
    localparam int EXP_DEPTH = 1024;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  seq;
        logic [7:0]  ack_next;
        logic [15:0] ack_bitmap;
        logic        last;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [31:0] i_cfg_wr_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_cmd = '0;
    logic [15:0] i_frame_length = '0;
    logic [7:0]  i_message_seq = '0;
    logic [7:0]  i_peer_next = '0;
    logic [15:0] i_peer_bitmap_in = '0;
    logic [31:0] i_now = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_seq;
    logic [7:0]  o_ack_next;
    logic [15:0] o_ack_bitmap;
    logic        o_last;

    // window model state
    logic [7:0]  tx_next_seq, rx_next_seq, peer_ack;
    logic [15:0] rx_bits, peer_bits;
    logic [31:0] last_resend, resend_interval;
    int          pending;

    // expected results, kept as a ring with running write and read counts
    t_result     exp_mem [EXP_DEPTH];
    int          exp_wr = 0;
    int          exp_rd = 0;
    int          errors = 0;
    int          in_idle_pct = 27;
    int          out_idle_pct = 27;
    int          hold_off_req = 0;
    int          hold_off_cnt = 0;
    int          quiet_cycles = 0;
    logic [31:0] now_us = '0;

    selective_repeat_arq_window i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_cmd(i_cmd), .i_frame_length(i_frame_length),
        .i_message_seq(i_message_seq), .i_peer_next(i_peer_next),
        .i_peer_bitmap_in(i_peer_bitmap_in), .i_now(i_now),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_kind(o_kind), .o_seq(o_seq), .o_ack_next(o_ack_next),
        .o_ack_bitmap(o_ack_bitmap), .o_last(o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic window_reset();
        tx_next_seq = '0; rx_next_seq = '0; peer_ack = '0;
        rx_bits = '0; peer_bits = '0; last_resend = '0;
        resend_interval = srarq_pkg::RESEND_RESET; pending = 0;
    endtask

    // Compute the results of one accepted transaction and queue them.
    task automatic predict_window(logic [1:0] cmd, logic [15:0] flen, logic [7:0] mseq,
                                  logic [7:0] pnext, logic [15:0] pbits, logic [31:0] now);
        t_result     res [srarq_pkg::WINDOW_SLOTS];
        t_result     r;
        logic [7:0]  d_new, d_old, idx, outstanding;
        int          lim;
        int          nres;
        nres = 0;
        case (cmd)
            srarq_pkg::CMD_QUEUE: begin
                if (pending >= srarq_pkg::PENDING_DEPTH) begin
                    r = '{srarq_pkg::KIND_REJECT, 8'd0, 8'd0, 16'd0, 1'b0};
                    res[nres] = r; nres++;
                end else begin
                    pending++;
                end
            end
            srarq_pkg::CMD_FRAME: begin
                if (flen >= srarq_pkg::MIN_FRAME) begin
                    d_new = tx_next_seq - pnext;
                    d_old = tx_next_seq - peer_ack;
                    if (d_new <= d_old) begin
                        peer_ack = pnext;
                        peer_bits = pbits;
                    end
                    idx = mseq - rx_next_seq;
                    if (idx < srarq_pkg::WINDOW_SLOTS && !rx_bits[idx[3:0]]) begin
                        rx_bits[idx[3:0]] = 1'b1;
                        while (rx_bits[0]) begin
                            rx_next_seq++;
                            rx_bits = rx_bits >> 1;
                        end
                        r = '{srarq_pkg::KIND_DELIVER, mseq, rx_next_seq, rx_bits, 1'b0};
                        res[nres] = r; nres++;
                    end
                end
            end
            srarq_pkg::CMD_UPDATE: begin
                d_old = tx_next_seq - peer_ack;
                while (pending > 0 && d_old < srarq_pkg::WINDOW_SLOTS &&
                       nres < srarq_pkg::WINDOW_SLOTS) begin
                    last_resend = now;
                    r = '{srarq_pkg::KIND_XMIT, tx_next_seq, rx_next_seq, rx_bits, 1'b0};
                    res[nres] = r; nres++;
                    tx_next_seq++;
                    pending--;
                    d_old = tx_next_seq - peer_ack;
                end
                outstanding = tx_next_seq - peer_ack;
                if (now - last_resend > resend_interval && outstanding > 0) begin
                    last_resend = now;
                    lim = (outstanding > srarq_pkg::WINDOW_SLOTS) ?
                          srarq_pkg::WINDOW_SLOTS : outstanding;
                    for (int i = 0; i < lim && nres < srarq_pkg::WINDOW_SLOTS; i++) begin
                        if (!peer_bits[i]) begin
                            r = '{srarq_pkg::KIND_RESEND, 8'(peer_ack + i), rx_next_seq,
                                  rx_bits, 1'b0};
                            res[nres] = r; nres++;
                        end
                    end
                end
            end
            default: ;
        endcase
        if (nres > 0) res[nres - 1].last = 1'b1;
        for (int k = 0; k < nres; k++) begin
            exp_mem[exp_wr % EXP_DEPTH] = res[k];
            exp_wr++;
        end
    endtask

    // Offer one transaction and hold it until accepted.
    task automatic send_item(logic [1:0] cmd, logic [15:0] flen, logic [7:0] mseq,
                             logic [7:0] pnext, logic [15:0] pbits, logic [31:0] now);
        if ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < in_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_frame_length <= flen;
        i_message_seq <= mseq;
        i_peer_next <= pnext;
        i_peer_bitmap_in <= pbits;
        i_now <= now;
        do @(posedge i_clk); while (!o_in_ready);
        predict_window(cmd, flen, mseq, pnext, pbits, now);
    endtask

    task automatic end_burst();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        end_burst();
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_interval(logic [31:0] value);
        wait_idle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        resend_interval = value;
        @(posedge i_clk);
    endtask

    // Frame acking a plausible point of the send window, message near the receive edge.
    task automatic send_good_frame();
        logic [7:0] span, pnext, mseq;
        span = tx_next_seq - peer_ack;
        pnext = tx_next_seq - 8'($urandom_range(0, span));
        mseq = rx_next_seq + 8'($urandom_range(0, 17));
        send_item(srarq_pkg::CMD_FRAME, 16'($urandom_range(5, 1500)), mseq, pnext,
                  16'($urandom), now_us);
    endtask

    task automatic send_random_item();
        int pick;
        pick = $urandom_range(99);
        now_us += $urandom_range(0, 3000);
        if ($urandom_range(49) == 0) now_us = $urandom;
        if (pick < 30)
            send_item(srarq_pkg::CMD_QUEUE, 16'($urandom), 8'($urandom), 8'($urandom),
                      16'($urandom), now_us);
        else if (pick < 62)
            send_good_frame();
        else if (pick < 72)
            send_item(srarq_pkg::CMD_FRAME, 16'($urandom), 8'($urandom), 8'($urandom),
                      16'($urandom), now_us);
        else if (pick < 96)
            send_item(srarq_pkg::CMD_UPDATE, 16'($urandom), 8'($urandom), 8'($urandom),
                      16'($urandom), now_us);
        else
            send_item(CMD_UNUSED, 16'($urandom), 8'($urandom), 8'($urandom),
                      16'($urandom), now_us);
    endtask

    task automatic test_directed();
        send_item(srarq_pkg::CMD_UPDATE, 16'd0, 8'd0, 8'd0, 16'd0, 32'd0);
        repeat (3) send_item(srarq_pkg::CMD_QUEUE, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 32'd5);
        send_item(srarq_pkg::CMD_UPDATE, 16'd0, 8'd0, 8'd0, 16'd0, 32'd10);
        // update well after transmit: the resend interval has passed, so a resend follows
        send_item(srarq_pkg::CMD_UPDATE, 16'd0, 8'd0, 8'd0, 16'd0, 32'd200000);
        send_item(srarq_pkg::CMD_UPDATE, 16'd0, 8'd0, 8'd0, 16'd0, 32'd400001);
        send_item(srarq_pkg::CMD_FRAME, 16'd0, 8'd0, 8'd1, 16'd0, 32'd0);
        send_item(srarq_pkg::CMD_FRAME, 16'd4, 8'd0, 8'd1, 16'd0, 32'd0);
        send_item(srarq_pkg::CMD_FRAME, 16'd5, 8'd1, 8'd1, 16'h0001, 32'd0);
        send_item(srarq_pkg::CMD_FRAME, 16'hFFFF, 8'd0, 8'd2, 16'hFFFF, 32'd0);
        // backward ack, duplicate
        send_item(srarq_pkg::CMD_FRAME, 16'd5, 8'd0, 8'd0, 16'd0, 32'd0);
        // near the far edge of the receive window
        send_item(srarq_pkg::CMD_FRAME, 16'd5, 8'd17, 8'd3, 16'd0, 32'd0);
        send_item(srarq_pkg::CMD_FRAME, 16'd5, 8'd16, 8'd3, 16'd0, 32'd0);
        // old message
        send_item(srarq_pkg::CMD_FRAME, 16'd5, 8'hFF, 8'd3, 16'd0, 32'd0);
        send_item(CMD_UNUSED, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFFFFFF);
        send_item(srarq_pkg::CMD_UPDATE, 16'd0, 8'd0, 8'd0, 16'd0, 32'hFFFFFFFF);
        send_item(srarq_pkg::CMD_UPDATE, 16'd0, 8'd0, 8'd0, 16'd0, 32'd700000);
        now_us = 32'd700000;
    endtask

    task automatic test_queue_full();
        repeat (srarq_pkg::PENDING_DEPTH + 3)
            send_item(srarq_pkg::CMD_QUEUE, 16'd0, 8'd0, 8'd0, 16'd0, now_us);
    endtask

    task automatic test_random(int count);
        repeat (count) send_random_item();
    endtask

    task automatic test_no_idle(int count);
        in_idle_pct = 0;
        out_idle_pct = 0;
        test_random(count);
        in_idle_pct = 27;
        out_idle_pct = 27;
    endtask

    task automatic test_backpressure();
        hold_off_req = 300;
        repeat (30) begin
            send_item(srarq_pkg::CMD_QUEUE, 16'd0, 8'd0, 8'd0, 16'd0, now_us);
            send_item(srarq_pkg::CMD_UPDATE, 16'd0, 8'd0, 8'd0, 16'd0, now_us);
            send_good_frame();
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_off_req > 0) begin
            hold_off_cnt <= hold_off_req;
            hold_off_req <= 0;
            i_out_ready <= 1'b0;
        end else if (hold_off_cnt > 0) begin
            hold_off_cnt <= hold_off_cnt - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (exp_wr == exp_rd) begin
                errors++;
                $error("unexpected result kind=%0d seq=%0d", o_kind, o_seq);
            end else begin
                e = exp_mem[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (o_kind !== e.kind) begin
                    errors++; $error("kind: expected %0d, got %0d", e.kind, o_kind);
                end
                if (o_seq !== e.seq) begin
                    errors++; $error("seq: expected %0d, got %0d", e.seq, o_seq);
                end
                if (o_ack_next !== e.ack_next) begin
                    errors++; $error("ack_next: expected %0d, got %0d", e.ack_next, o_ack_next);
                end
                if (o_ack_bitmap !== e.ack_bitmap) begin
                    errors++;
                    $error("ack_bitmap: expected %h, got %h", e.ack_bitmap, o_ack_bitmap);
                end
                if (o_last !== e.last) begin
                    errors++; $error("last: expected %0d, got %0d", e.last, o_last);
                end
            end
        end
    end

    // Count stalled cycles while work is outstanding.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (!i_in_valid && exp_wr == exp_rd)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("selective_repeat_arq_window_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        window_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_queue_full();
        write_interval(32'd2000);
        test_random(100);
        test_backpressure();
        write_interval(32'd0);
        test_no_idle(60);
        write_interval(32'hFFFFFFFF);
        test_random(40);
        write_interval(32'd5000);
        test_random(60);
        wait_idle();
        if (errors == 0) begin
            $display("selective_repeat_arq_window_tb: done, clean");
        end else begin
            $display("selective_repeat_arq_window_tb: done, errors");
        end
        $finish;
    end
endmodule
